// File: sv/dbrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrs_pkg
// Shared codes, field widths and the slot memory request type.
// ----------------------------------------------------------------------------
package dbrs_pkg;

    localparam int OP_W     = 2;
    localparam int COUNT_W  = 17;
    localparam int SLOT_W   = 3;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;

    // widest slot index over the supported ring depths
    localparam int IDX_MAX_W = 6;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int SLOT_BYTES_DEF = 124 * 1024;

    localparam logic [OP_W-1:0] OP_SUBMIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_BIND     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic                 addr_we;
        logic [IDX_MAX_W-1:0] addr_widx;
        logic [ADDR_W-1:0]    addr_wdata;
        logic                 cnt_we;
        logic [IDX_MAX_W-1:0] cnt_widx;
        logic [COUNT_W-1:0]   cnt_wdata;
        logic                 rd_en;
        logic [IDX_MAX_W-1:0] addr_ridx;
        logic [IDX_MAX_W-1:0] cnt_ridx;
    } t_mem_req;

endpackage

// File: sv/dbrs_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrs_slot_mem
// Slot address and byte count stores, one write and one registered read each.
// ----------------------------------------------------------------------------
module dbrs_slot_mem
    import dbrs_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int PW         = $clog2(SLOT_COUNT)
) (
    input  logic               i_clk,
    input  t_mem_req           i_req,
    output logic [ADDR_W-1:0]  o_rd_address,
    output logic [COUNT_W-1:0] o_rd_count
);

    logic [ADDR_W-1:0]  mem_addr [SLOT_COUNT];
    logic [COUNT_W-1:0] mem_cnt  [SLOT_COUNT];
    logic [ADDR_W-1:0]  r_rd_address;
    logic [COUNT_W-1:0] r_rd_count;

    always_ff @(posedge i_clk) begin
        if (i_req.addr_we) begin
            mem_addr[i_req.addr_widx[PW-1:0]] <= i_req.addr_wdata;
        end
        if (i_req.cnt_we) begin
            mem_cnt[i_req.cnt_widx[PW-1:0]] <= i_req.cnt_wdata;
        end
        // read data holds while no read is issued
        if (i_req.rd_en) begin
            r_rd_address <= mem_addr[i_req.addr_ridx[PW-1:0]];
            r_rd_count   <= mem_cnt[i_req.cnt_ridx[PW-1:0]];
        end
    end

    assign o_rd_address = r_rd_address;
    assign o_rd_count   = r_rd_count;

endmodule

// File: sv/dma_buffer_ring_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_buffer_ring_scheduler
// Ring of DMA buffer slots: submit, completion and slot address bind.
// ----------------------------------------------------------------------------
// An accepted beat goes through stage 1 and stage 2 to its result beat.
// Throughput: one beat per cycle while the output is taken; the slot memory
// read issued at acceptance sets the decide -> read -> output pipeline.
// Reset (synchronous, active low) empties the ring: pointers and occupancy
// go to zero, both pipeline stages go empty. Slot addresses stay undefined
// until bound; no clearing pass is needed.
module dma_buffer_ring_scheduler
    import dbrs_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input beats
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [COUNT_W-1:0]  i_byte_count,
    input  logic [SLOT_W-1:0]   i_slot_number,
    input  logic [ADDR_W-1:0]   i_bus_address,
    // result beats
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_start_valid,
    output logic [ADDR_W-1:0]   o_start_address,
    output logic [COUNT_W-1:0]  o_start_count,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_next_fill_slot
);

    localparam int PW = $clog2(SLOT_COUNT);      // slot pointer width
    localparam int OW = $clog2(SLOT_COUNT + 1);  // occupancy holds SLOT_COUNT
    localparam logic [PW-1:0]   LastSlot  = PW'(SLOT_COUNT - 1);
    localparam logic [OW-1:0]   OccFull   = OW'(SLOT_COUNT);
    localparam logic [31:0]     SlotBytes = 32'(SLOT_BYTES);
    localparam logic [31:0]     SlotCnt   = 32'(SLOT_COUNT);

    // Ring control. Slots from drain up to occupancy are full, so the
    // per-slot full marks follow from the pointers and the occupancy.
    logic [PW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_drain, n_drain;
    logic [OW-1:0] r_occ, n_occ;

    // Stage 1: decision made, slot memory read in flight
    logic                r_s1_valid;
    logic                r_s1_start;
    logic                r_s1_cnt_from_mem;
    logic [COUNT_W-1:0]  r_s1_count;
    logic [STATUS_W-1:0] r_s1_status;
    logic [SLOT_W-1:0]   r_s1_fill;

    // Stage 2: output register
    logic                r_out_valid;
    logic                r_out_start;
    logic [ADDR_W-1:0]   r_out_address;
    logic [COUNT_W-1:0]  r_out_count;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_fill;

    logic               accept;
    logic               advance;
    logic               start;
    logic               cnt_from_mem;
    logic [STATUS_W-1:0] status;
    logic [PW-1:0]      fill_inc;
    logic [PW-1:0]      drain_inc;
    logic [31:0]        fill_ext;
    logic [PW-1:0]      rd_slot;
    t_mem_req           mem_req;
    logic [ADDR_W-1:0]  rd_address;
    logic [COUNT_W-1:0] rd_count;

    // Stage 1 moves on when the output register is free or being emptied.
    // The read data register only loads on acceptance, so a held stage 1
    // keeps its read data.
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    assign fill_inc  = (r_fill == LastSlot)  ? '0 : r_fill + 1'b1;
    assign drain_inc = (r_drain == LastSlot) ? '0 : r_drain + 1'b1;

    always_comb begin
        n_fill       = r_fill;
        n_drain      = r_drain;
        n_occ        = r_occ;
        start        = 1'b0;
        cnt_from_mem = 1'b0;
        status       = ST_OK;
        rd_slot      = r_fill;
        mem_req      = '0;
        case (i_op)
            OP_SUBMIT: begin
                if (i_byte_count == '0) begin
                    status = ST_ZERO;
                end else if ({15'd0, i_byte_count} > SlotBytes) begin
                    status = ST_TOO_LARGE;
                end else if (r_occ == OccFull) begin
                    status = ST_FULL;
                end else begin
                    mem_req.cnt_we    = accept;
                    mem_req.cnt_widx  = IDX_MAX_W'(r_fill);
                    mem_req.cnt_wdata = i_byte_count;
                    // idle ring: this slot starts now, count from the beat
                    start   = (r_occ == '0);
                    rd_slot = r_fill;
                    n_fill  = fill_inc;
                    n_occ   = r_occ + 1'b1;
                end
            end
            OP_COMPLETE: begin
                if (r_occ == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_drain = drain_inc;
                    n_occ   = r_occ - 1'b1;
                    // another slot still pending behind the freed one
                    start        = (r_occ > OW'(1));
                    cnt_from_mem = 1'b1;
                    rd_slot      = drain_inc;
                end
            end
            OP_BIND: begin
                // slots beyond the ring are ignored
                mem_req.addr_we    = accept && ({29'd0, i_slot_number} < SlotCnt);
                mem_req.addr_widx  = IDX_MAX_W'(i_slot_number);
                mem_req.addr_wdata = i_bus_address;
            end
            default: begin
            end
        endcase
        mem_req.rd_en     = accept;
        mem_req.addr_ridx = IDX_MAX_W'(rd_slot);
        mem_req.cnt_ridx  = IDX_MAX_W'(rd_slot);
    end

    assign fill_ext = 32'(n_fill);

    dbrs_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .PW         (PW)
    ) u_slot_mem (
        .i_clk        (i_clk),
        .i_req        (mem_req),
        .o_rd_address (rd_address),
        .o_rd_count   (rd_count)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_drain     <= '0;
            r_occ       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill  <= n_fill;
                r_drain <= n_drain;
                r_occ   <= n_occ;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_start        <= start;
            r_s1_cnt_from_mem <= cnt_from_mem;
            r_s1_count        <= i_byte_count;
            r_s1_status       <= status;
            r_s1_fill         <= fill_ext[SLOT_W-1:0];
        end
        if (advance) begin
            r_out_start   <= r_s1_start;
            r_out_address <= r_s1_start ? rd_address : '0;
            if (!r_s1_start) begin
                r_out_count <= '0;
            end else if (r_s1_cnt_from_mem) begin
                r_out_count <= rd_count;
            end else begin
                r_out_count <= r_s1_count;
            end
            r_out_status <= r_s1_status;
            r_out_fill   <= r_s1_fill;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_start_valid    = r_out_start;
    assign o_start_address  = r_out_address;
    assign o_start_count    = r_out_count;
    assign o_status         = r_out_status;
    assign o_next_fill_slot = r_out_fill;

endmodule

// File: sv/dbrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbrs_checker
// Port-level checks on the result channel of the ring scheduler.
// ----------------------------------------------------------------------------
module dbrs_checker
    import dbrs_pkg::*;
#(
    parameter int SLOT_BYTES = SLOT_BYTES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_start_valid,
    input logic [ADDR_W-1:0]   o_start_address,
    input logic [COUNT_W-1:0]  o_start_count,
    input logic [STATUS_W-1:0] o_status,
    input logic [SLOT_W-1:0]   o_next_fill_slot
);

    localparam logic [31:0] SlotBytes = 32'(SLOT_BYTES);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_start_valid)
            && $stable(o_start_count) && $stable(o_status)
            && $stable(o_next_fill_slot))
        else $error("stalled result beat changed");

    // a result with no start carries zero address and count
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_start_valid |-> o_start_address == '0 && o_start_count == '0)
        else $error("address or count without start");

    // only accepted beats may start a transfer, with a legal nonzero count
    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_valid |-> o_status == ST_OK && o_start_count != '0
            && {15'd0, o_start_count} <= SlotBytes)
        else $error("start with bad status or count");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind dma_buffer_ring_scheduler dbrs_checker #(
    .SLOT_BYTES (SLOT_BYTES)
) u_dbrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_start_valid    (o_start_valid),
    .o_start_address  (o_start_address),
    .o_start_count    (o_start_count),
    .o_status         (o_status),
    .o_next_fill_slot (o_next_fill_slot)
);
